[sv/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)

`define ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

[sv/pcfpa_pkg.sv]
// Types, constants and codes of the per-CPU free page allocator.
// No dependencies; imported by every allocator module except the generic pcfpa_ram.
package pcfpa_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;

    localparam int CPU_W  = $clog2(NUM_CPUS);
    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int OFFS_W = $clog2(PAGE_BYTES);
    localparam int LINK_W = PAGE_W + 1;
    localparam int ADDR_W = 24;
    localparam int CFG_W  = 25;

    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam int PADDR_W   = REG_IDX_W + 2;

    localparam logic [CFG_W-1:0] MEM_START_RST = '0;
    localparam logic [CFG_W-1:0] MEM_END_RST   = CFG_W'(1 << ADDR_W);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MEM_START = 1'b0,
        REG_MEM_END   = 1'b1
    } reg_idx_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [CPU_W-1:0]  cpu;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        status_t           status;
        logic              stolen;
        logic [CPU_W-1:0]  source_cpu;
    } rsp_t;

    typedef struct packed {
        logic accept_free;
        logic pop_start;
        logic oom;
        logic pop_done;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic any_avail;
    } dp_status_t;

endpackage

[sv/pcfpa_ram.sv]
// Single-port-write, single-port-read RAM with registered read data.
// Generic; no package dependencies.
module pcfpa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 13
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/pcfpa_datapath.sv]
// Datapath: config registers, list heads, link memory and result register.
// Depends on pcfpa_pkg, pcfpa_ram and assert_macros.svh.
`include "assert_macros.svh"

module pcfpa_datapath
    import pcfpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  ctrl_cmd_t            ctl,
    output dp_status_t           status,
    output rsp_t                 rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata
);

    logic [CFG_W-1:0]  mem_start_reg;
    logic [CFG_W-1:0]  mem_end_reg;
    logic [PAGE_W-1:0] list_head_reg [NUM_CPUS];
    logic [NUM_CPUS-1:0] list_nonempty_reg;
    logic [CPU_W-1:0]  sel_cpu_reg;
    logic              stolen_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    reg_idx_t          reg_idx;
    logic              cfg_wr;
    logic [CPU_W-1:0]  low_cpu;
    logic              own_avail;
    logic [CPU_W-1:0]  pick_cpu;
    logic [PAGE_W-1:0] free_page;
    logic              free_ok;
    logic [LINK_W-1:0] link_wdata;
    logic [LINK_W-1:0] link_rdata;
    logic [PAGE_W-1:0] pop_page;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_MEM_START: prdata = PDATA_W'(mem_start_reg);
            REG_MEM_END:   prdata = PDATA_W'(mem_end_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        low_cpu = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (list_nonempty_reg[i])
            begin
                low_cpu = CPU_W'(i);
            end
        end
    end

    assign own_avail = list_nonempty_reg[req.cpu];
    assign pick_cpu  = own_avail ? req.cpu : low_cpu;

    assign status.cmd       = req.cmd;
    assign status.any_avail = |list_nonempty_reg;

    assign free_page = req.address[OFFS_W +: PAGE_W];
    assign free_ok   = (req.address[OFFS_W-1:0] == '0)
                    && ({1'b0, req.address} >= mem_start_reg)
                    && ({1'b0, req.address} <  mem_end_reg)
                    && ({1'b0, (req.address >> OFFS_W)} < (ADDR_W + 1)'(NUM_PAGES));

    assign link_wdata = own_avail ? ({1'b0, list_head_reg[req.cpu]} + LINK_W'(1)) : '0;
    assign pop_page   = list_head_reg[sel_cpu_reg];

    pcfpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (ctl.accept_free && free_ok),
        .waddr (free_page),
        .wdata (link_wdata),
        .re    (ctl.pop_start),
        .raddr (list_head_reg[pick_cpu]),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_start_reg     <= MEM_START_RST;
            mem_end_reg       <= MEM_END_RST;
            list_nonempty_reg <= '0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                list_head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (reg_idx)
                    REG_MEM_START: mem_start_reg <= pwdata[CFG_W-1:0];
                    REG_MEM_END:   mem_end_reg   <= pwdata[CFG_W-1:0];
                    default:       ;
                endcase
            end
            if (ctl.accept_free && free_ok)
            begin
                list_head_reg[req.cpu]     <= free_page;
                list_nonempty_reg[req.cpu] <= 1'b1;
            end
            if (ctl.pop_done)
            begin
                if (link_rdata == '0)
                begin
                    list_head_reg[sel_cpu_reg]     <= '0;
                    list_nonempty_reg[sel_cpu_reg] <= 1'b0;
                end
                else
                begin
                    list_head_reg[sel_cpu_reg] <= PAGE_W'(link_rdata - LINK_W'(1));
                end
            end
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (ctl.pop_done)
        begin
            rsp_next.page_address = ADDR_W'({pop_page, {OFFS_W{1'b0}}});
            rsp_next.status       = ST_OK;
            rsp_next.stolen       = stolen_reg;
            rsp_next.source_cpu   = sel_cpu_reg;
        end
        else if (ctl.accept_free || ctl.oom)
        begin
            rsp_next.page_address = '0;
            rsp_next.status       = ctl.oom ? ST_OOM : (free_ok ? ST_OK : ST_BAD);
            rsp_next.stolen       = 1'b0;
            rsp_next.source_cpu   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (ctl.pop_start)
        begin
            sel_cpu_reg <= pick_cpu;
            stolen_reg  <= !own_avail;
        end
    end

    assign rsp = rsp_reg;

    `ASSERT_ALWAYS(a_pop_list_nonempty, clk, rst_n,
        ctl.pop_done |-> list_nonempty_reg[sel_cpu_reg], "pop from an empty list")
    `ASSERT_ALWAYS(a_push_sets_nonempty, clk, rst_n,
        (ctl.accept_free && free_ok) |=> list_nonempty_reg[$past(req.cpu)],
        "push left list empty")
    `ASSERT_NEVER(a_pop_no_overlap, clk, rst_n,
        ctl.pop_done && (ctl.accept_free || ctl.pop_start || ctl.oom),
        "new beat taken during pop")

endmodule

[sv/pcfpa_ctrl.sv]
// Controller: accepts request beats, sequences the link read, owns rsp_valid.
// Depends on pcfpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcfpa_ctrl
    import pcfpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctl
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;
    logic   load;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign ctl.accept_free = accept && (status.cmd == CMD_FREE);
    assign ctl.pop_start   = accept && (status.cmd == CMD_ALLOC) && status.any_avail;
    assign ctl.oom         = accept && (status.cmd == CMD_ALLOC) && !status.any_avail;
    assign ctl.pop_done    = (state_reg == S_POP);

    assign load = ctl.accept_free || ctl.oom || ctl.pop_done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (ctl.pop_start) state_next = S_POP;
            S_POP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        priority if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `ASSERT_ALWAYS(a_pop_one_cycle, clk, rst_n,
        (state_reg == S_POP) |=> (state_reg == S_IDLE), "pop held over")
    `ASSERT_NEVER(a_pop_rsp_free, clk, rst_n,
        (state_reg == S_POP) && rsp_valid_reg, "result slot busy at pop")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n,
        load && rsp_valid_reg && !rsp_ready, "pending result overwritten")

endmodule

[sv/per_cpu_free_page_allocator.sv]
// Top level of the per-CPU free page allocator with stealing.
// Depends on pcfpa_pkg, pcfpa_ctrl and pcfpa_datapath.
//
//   channel   handshake                  payload
//   req       req_valid / req_ready      req   (req_t: cmd, cpu, address)
//   rsp       rsp_valid / rsp_ready      rsp   (rsp_t: page_address, status, ...)
//   cfg       psel / penable / pready    paddr, pwdata, prdata
//
// Free and out-of-memory allocate: the result register is loaded in the cycle after accept.
// Allocate that finds a page: the link memory read is registered, then S_POP loads the result register.
// A new beat is taken once no pop is pending and the result register is empty
// or being drained.
// Reset clears all lists and loads mem_start = 0, mem_end = 2^24; no clearing pass.
module per_cpu_free_page_allocator
    import pcfpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    ctrl_cmd_t  ctl;
    dp_status_t status;

    assign pready = 1'b1;

    pcfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .ctl       (ctl)
    );

    pcfpa_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .ctl     (ctl),
        .status  (status),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for per_cpu_free_page_allocator: directed and random alloc/free beats,
// checked against a shadow copy of the per-CPU free lists. Depends on pcfpa_pkg and the RTL.
module tb;
    import pcfpa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_BEATS = 150;

    class free_list_shadow;
        logic [PAGE_W-1:0] head [NUM_CPUS];
        logic              nonempty [NUM_CPUS];
        logic [LINK_W-1:0] link [NUM_PAGES];
        logic [CFG_W-1:0]  lo_bound;
        logic [CFG_W-1:0]  hi_bound;
        rsp_t              owed [$];
        logic [PAGE_W-1:0] handed_out [$];
        int                errors;

        function new();
            foreach (head[i])
            begin
                head[i] = '0;
                nonempty[i] = 1'b0;
            end
            foreach (link[i])
                link[i] = '0;
            lo_bound = MEM_START_RST;
            hi_bound = MEM_END_RST;
            errors = 0;
        endfunction

        function logic [PAGE_W-1:0] pop_page(int c);
            logic [PAGE_W-1:0] page;
            page = head[c];
            if (link[page] == '0)
            begin
                nonempty[c] = 1'b0;
                head[c] = '0;
            end
            else
                head[c] = PAGE_W'(link[page] - 1'b1);
            return page;
        endfunction

        function void note_request(req_t r);
            rsp_t              exp;
            int                c;
            int                src;
            logic [PAGE_W-1:0] page;
            logic [CFG_W-1:0]  addr_x;
            exp = '0;
            exp.status = ST_OK;
            c = int'(r.cpu) % NUM_CPUS;
            if (r.cmd == CMD_FREE)
            begin
                addr_x = {1'b0, r.address};
                page = r.address[ADDR_W-1:OFFS_W];
                if (r.address[OFFS_W-1:0] != '0 || addr_x < lo_bound || addr_x >= hi_bound ||
                    (r.address >> OFFS_W) >= NUM_PAGES)
                    exp.status = ST_BAD;
                else
                begin
                    link[page] = nonempty[c] ? LINK_W'(head[c]) + 1'b1 : '0;
                    head[c] = page;
                    nonempty[c] = 1'b1;
                end
            end
            else
            begin
                src = -1;
                if (nonempty[c])
                    src = c;
                else
                    for (int i = 0; i < NUM_CPUS; i++)
                        if (src < 0 && nonempty[i])
                            src = i;
                if (src < 0)
                    exp.status = ST_OOM;
                else
                begin
                    page = pop_page(src);
                    exp.page_address = {page, OFFS_W'(0)};
                    exp.stolen = (src != c);
                    exp.source_cpu = CPU_W'(src);
                    handed_out.push_back(page);
                end
            end
            owed.push_back(exp);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_reply(rsp_t got);
            rsp_t exp;
            if (owed.size() == 0)
            begin
                flag_mismatch($sformatf("reply %h with nothing outstanding", got));
                return;
            end
            exp = owed.pop_front();
            if (got.page_address !== exp.page_address)
                flag_mismatch($sformatf("page_address got %h want %h",
                                        got.page_address, exp.page_address));
            if (got.status !== exp.status)
                flag_mismatch($sformatf("status got %0d want %0d", got.status, exp.status));
            if (got.stolen !== exp.stolen)
                flag_mismatch($sformatf("stolen got %b want %b", got.stolen, exp.stolen));
            if (got.source_cpu !== exp.source_cpu)
                flag_mismatch($sformatf("source_cpu got %0d want %0d",
                                        got.source_cpu, exp.source_cpu));
        endtask

        task close_out();
            if (owed.size() != 0)
                flag_mismatch($sformatf("%0d replies never arrived", owed.size()));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    free_list_shadow ledger = new();

    per_cpu_free_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            ledger.check_reply(rsp);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic req_t beat_of(cmd_t c, int cpu, logic [ADDR_W-1:0] a);
        req_t b;
        b.cmd = c;
        b.cpu = CPU_W'(cpu);
        b.address = a;
        return b;
    endfunction

    function automatic req_t random_beat();
        req_t              b;
        int                roll;
        int                first_pg;
        int                last_pg;
        int                idx;
        logic [PAGE_W-1:0] pg;
        b.cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
        b.address = ADDR_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 50)
            b.cmd = CMD_ALLOC;
        else
        begin
            b.cmd = CMD_FREE;
            if (roll < 88)
            begin
                first_pg = (ledger.lo_bound + PAGE_BYTES - 1) / PAGE_BYTES;
                last_pg = (ledger.hi_bound == 0) ? -1 : (ledger.hi_bound - 1) / PAGE_BYTES;
                if (last_pg > NUM_PAGES - 1)
                    last_pg = NUM_PAGES - 1;
                if (ledger.handed_out.size() != 0 && $urandom_range(0, 99) < 70)
                begin
                    idx = $urandom_range(0, ledger.handed_out.size() - 1);
                    pg = ledger.handed_out[idx];
                    ledger.handed_out.delete(idx);
                end
                else if (first_pg <= last_pg)
                    pg = PAGE_W'($urandom_range(first_pg, last_pg));
                else
                    pg = PAGE_W'($urandom);
                b.address = {pg, OFFS_W'(0)};
            end
            else if (roll < 94)
                b.address = {b.address[ADDR_W-1:OFFS_W], OFFS_W'(0)};
        end
        return b;
    endfunction

    task send_beat(input req_t beat);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        ledger.note_request(beat);
    endtask

    task wait_drained();
        req_valid <= 1'b0;
        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MEM_START)
            ledger.lo_bound = value;
        else
            ledger.hi_bound = value;
        @(posedge clk);
    endtask

    task set_window(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        wait_drained();
        cfg_write(REG_MEM_START, lo);
        cfg_write(REG_MEM_END, hi);
    endtask

    initial
    begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        req_valid <= 1'b0;
        req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(beat_of(CMD_ALLOC, 0, 24'h000000));
        send_beat(beat_of(CMD_ALLOC, 7, 24'hFFFFFF));
        send_beat(beat_of(CMD_FREE, 0, 24'h000000));
        send_beat(beat_of(CMD_ALLOC, 0, 24'h000000));
        send_beat(beat_of(CMD_FREE, 7, 24'hFFF000));
        send_beat(beat_of(CMD_FREE, 3, 24'hFFFFFF));
        send_beat(beat_of(CMD_FREE, 3, 24'h000001));
        send_beat(beat_of(CMD_FREE, 3, 24'h800800));
        send_beat(beat_of(CMD_ALLOC, 2, 24'h000000));
        send_beat(beat_of(CMD_FREE, 3, 24'h005000));
        send_beat(beat_of(CMD_FREE, 5, 24'h006000));
        send_beat(beat_of(CMD_ALLOC, 0, 24'hABCDEF));
        send_beat(beat_of(CMD_ALLOC, 5, 24'h000000));
        // double free, then overwrite the link from another list
        send_beat(beat_of(CMD_FREE, 1, 24'h009000));
        send_beat(beat_of(CMD_FREE, 1, 24'h009000));
        send_beat(beat_of(CMD_FREE, 4, 24'h009000));
        send_beat(beat_of(CMD_ALLOC, 1, 24'h000000));
        send_beat(beat_of(CMD_ALLOC, 1, 24'h000000));
        send_beat(beat_of(CMD_ALLOC, 6, 24'h000000));

        set_window(CFG_W'(1 << ADDR_W), '0);
        send_beat(beat_of(CMD_FREE, 0, 24'h000000));
        send_beat(beat_of(CMD_FREE, 0, 24'hFFF000));

        set_window(CFG_W'(24'h010000), CFG_W'(24'h020000));
        send_beat(beat_of(CMD_FREE, 2, 24'h00F000));
        send_beat(beat_of(CMD_FREE, 2, 24'h010000));
        send_beat(beat_of(CMD_FREE, 2, 24'h01F000));
        send_beat(beat_of(CMD_FREE, 2, 24'h020000));
        send_beat(beat_of(CMD_ALLOC, 2, 24'h000000));
        send_beat(beat_of(CMD_ALLOC, 2, 24'h000000));

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                1, 5:
                begin
                    lo = CFG_W'($urandom_range(0, 1 << 23));
                    hi = lo + CFG_W'($urandom_range(1 << 16, 1 << 23));
                end
                2:
                begin
                    lo = CFG_W'($urandom_range(0, 1 << 24));
                    hi = CFG_W'($urandom_range(0, 1 << 24));
                end
                4:
                begin
                    lo = CFG_W'($urandom_range(0, NUM_PAGES - 16)) << OFFS_W;
                    hi = lo + CFG_W'(16 * PAGE_BYTES);
                end
                default:
                begin
                    lo = MEM_START_RST;
                    hi = MEM_END_RST;
                end
            endcase
            set_window(lo, hi);
            if (ph < 2)
            begin
                send_idle = 24;
                recv_idle = 50;
            end
            else if (ph < 4)
            begin
                send_idle = 50;
                recv_idle = 24;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // hold off until every reply is back
                if (n == PHASE_BEATS / 2)
                    wait_drained();
                send_beat(random_beat());
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        ledger.close_out();
        if (ledger.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
